@@ hw/rtl/display_gpio_palette_registers_macros.svh @@
// ----------------------------------------------------------------------------
// Display/GPIO register block: assertion macros
// Shared assertion wrappers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_GPIO_PALETTE_REGISTERS_MACROS_SVH
`define DISPLAY_GPIO_PALETTE_REGISTERS_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define DGPR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle property");
// Consequent in the cycle after the antecedent.
`define DGPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property");
`else
`define DGPR_ASSERT_SAME(label, clk, rst, ante, cons)
`define DGPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/dgpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Display/GPIO register block package
// Sizes, request codes and register map constants.
// ----------------------------------------------------------------------------
package dgpr_pkg;

   localparam int PALETTE_WORDS = 512;
   localparam int BLIT_REGS     = 16;

   localparam int PAL_IDX_W  = (PALETTE_WORDS > 1) ? $clog2(PALETTE_WORDS) : 1;
   localparam int BLIT_IDX_W = (BLIT_REGS > 1) ? $clog2(BLIT_REGS) : 1;
   localparam int BLIT_BYTES = BLIT_REGS * 4;

   typedef enum logic [2:0] {
      REQ_READ16  = 3'd0,
      REQ_WRITE16 = 3'd1,
      REQ_READ32  = 3'd2,
      REQ_WRITE32 = 3'd3,
      REQ_FLIP    = 3'd4
   } req_kind_type;

   // Address windows
   localparam logic [15:0] IO_PAGE16   = 16'h7f00;
   localparam logic [11:0] IO_PAGE12   = 12'h7f0;
   localparam logic [11:0] BLIT_PAGE12 = 12'h7f1;

   // 16-bit register offsets
   localparam logic [15:0] REG_ID_A      = 16'h0910;
   localparam logic [15:0] REG_ID_B      = 16'h0912;
   localparam logic [15:0] REG_GPIOC     = 16'h1184;
   localparam logic [15:0] REG_GPIOD     = 16'h1186;
   localparam logic [15:0] REG_GPIOM     = 16'h1198;
   localparam logic [15:0] REG_MISC      = 16'h1836;
   localparam logic [15:0] REG_WIDTH     = 16'h2816;
   localparam logic [15:0] REG_HEIGHT    = 16'h2818;
   localparam logic [15:0] REG_LAYER_CTL = 16'h28da;
   localparam logic [15:0] REG_FB_LO_A   = 16'h290e;
   localparam logic [15:0] REG_FB_HI_A   = 16'h2910;
   localparam logic [15:0] REG_FB_LO_B   = 16'h2912;
   localparam logic [15:0] REG_FB_HI_B   = 16'h2914;
   localparam logic [15:0] REG_PAL_ADDR  = 16'h2958;
   localparam logic [15:0] REG_PAL_DATA  = 16'h295a;

   localparam logic [11:0] BLIT_RUN_OFF = 12'h034;

   // Fixed read values and masks
   localparam logic [15:0] ID_VALUE      = 16'h9407;
   localparam logic [15:0] GPIOD_PAD     = 16'h373b;
   localparam logic [15:0] GPIOM_PAD     = 16'h01aa;
   localparam logic [15:0] MISC_VALUE    = 16'h2330;
   localparam logic [15:0] WIDTH_VALUE   = 16'd319;
   localparam logic [15:0] HEIGHT_VALUE  = 16'd239;
   localparam logic [15:0] LAYER_OR_MASK = 16'h00aa;
   localparam logic [15:0] LAYER_RESET   = 16'h04ab;
   localparam logic [31:0] FRAME_RESET   = 32'h0310_1000;

endpackage

@@ hw/rtl/display_gpio_palette_registers.sv @@
// ----------------------------------------------------------------------------
// Display/GPIO register block
// Bus register file with palette RAM, blitter register memory and flip event.
// ----------------------------------------------------------------------------
// One request beat is taken per cycle as long as result beats are taken. A
// result is registered in the stage after the memory read, which holds the
// registered blitter memory read, then in the output register; every beat
// passes through that stage to keep results in order. The blitter registers
// carry one valid flip-flop each, cleared by reset, so there is no clearing
// pass and the block is ready straight after reset. Palette RAM is write only.
`include "display_gpio_palette_registers_macros.svh"

module display_gpio_palette_registers (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [18:0] req_buttons,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_blit_start,
   output logic        rsp_refresh_request,
   output logic        rsp_palette_changed,
   output logic [4:0]  rsp_display_bpp,
   output logic [31:0] rsp_frame_base
);

   // Architectural registers
   logic [15:0] layer_ctl_ff,  layer_ctl_in;
   logic [31:0] frame_addr_ff, frame_addr_in;
   logic [31:0] prev_frame_ff, prev_frame_in;
   logic [dgpr_pkg::PAL_IDX_W-1:0] pal_idx_ff, pal_idx_in;
   logic        pal_dirty_ff,  pal_dirty_in;
   logic [18:0] btn_latch_ff,  btn_latch_in;
   logic [15:0] toggle_ff,     toggle_in;
   logic [31:0] last_unk_ff,   last_unk_in;
   logic [dgpr_pkg::BLIT_REGS-1:0] blit_valid_ff, blit_valid_in;

   // Memories
   logic [15:0] pal_mem  [dgpr_pkg::PALETTE_WORDS];
   logic [31:0] blit_mem [dgpr_pkg::BLIT_REGS];
   logic [31:0] blit_rdata_ff;
   logic        blit_rvalid_ff;

   // Stage after the memory read
   logic        s1_valid_ff;
   logic [31:0] s1_rdata_ff,   s1_rdata_in;
   logic        s1_use_mem_ff, s1_use_mem_in;
   logic        s1_start_ff,   s1_start_in;
   logic        s1_refresh_ff, s1_refresh_in;
   logic        s1_palchg_ff,  s1_palchg_in;
   logic [4:0]  s1_bpp_ff,     s1_bpp_in;
   logic [31:0] s1_base_ff,    s1_base_in;

   // Output register
   logic        out_valid_ff;
   logic [31:0] out_rdata_ff;
   logic        out_start_ff, out_refresh_ff, out_palchg_ff;
   logic [4:0]  out_bpp_ff;
   logic [31:0] out_base_ff;

   logic        accept;
   logic        s1_move;
   logic        pal_wr_en;
   logic        blit_rd_en;
   logic        blit_wr_en;
   logic        rd16_hit;
   logic        blit_hit;
   logic [11:0] blit_off;
   logic [dgpr_pkg::BLIT_IDX_W-1:0] blit_idx;
   logic [15:0] wd16;
   logic [31:0] frame_hi_new;
   logic [1:0]  mode;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   assign wd16         = req_write_data[15:0];
   assign blit_off     = req_address[11:0];
   assign blit_idx     = blit_off[dgpr_pkg::BLIT_IDX_W+1:2];
   assign blit_hit     = (req_address[31:20] == dgpr_pkg::BLIT_PAGE12) &&
                         (blit_off < 12'(dgpr_pkg::BLIT_BYTES));
   assign frame_hi_new = {wd16, frame_addr_ff[15:0]};
   assign mode         = layer_ctl_ff[10:9];

   always_comb begin
      layer_ctl_in   = layer_ctl_ff;
      frame_addr_in  = frame_addr_ff;
      prev_frame_in  = prev_frame_ff;
      pal_idx_in     = pal_idx_ff;
      pal_dirty_in   = pal_dirty_ff;
      btn_latch_in   = btn_latch_ff;
      toggle_in      = toggle_ff;
      last_unk_in    = last_unk_ff;
      blit_valid_in  = blit_valid_ff;
      pal_wr_en      = 1'b0;
      blit_rd_en     = 1'b0;
      blit_wr_en     = 1'b0;
      rd16_hit       = 1'b0;
      s1_rdata_in    = '0;
      s1_use_mem_in  = 1'b0;
      s1_start_in    = 1'b0;
      s1_refresh_in  = 1'b0;
      s1_palchg_in   = 1'b0;
      s1_bpp_in      = '0;
      s1_base_in     = '0;
      if (accept) begin
         case (req_type)
            dgpr_pkg::REQ_READ16: begin
               if (req_address[31:16] == dgpr_pkg::IO_PAGE16) begin
                  rd16_hit = 1'b1;
                  case (req_address[15:0])
                     dgpr_pkg::REG_ID_A, dgpr_pkg::REG_ID_B:
                        s1_rdata_in = {16'h0, dgpr_pkg::ID_VALUE};
                     dgpr_pkg::REG_GPIOC:
                        s1_rdata_in = {16'h0, ~btn_latch_ff[15:8], 8'hff};
                     dgpr_pkg::REG_GPIOD: begin
                        // Buttons 16 to 18 land on scattered GPIOD pins.
                        s1_rdata_in = {16'h0, dgpr_pkg::GPIOD_PAD |
                                       {4'h0, ~btn_latch_ff[18], 3'h0,
                                        ~btn_latch_ff[16], ~btn_latch_ff[17], 6'h0}};
                     end
                     dgpr_pkg::REG_GPIOM: begin
                        btn_latch_in = req_buttons;
                        s1_rdata_in  = {16'h0, dgpr_pkg::GPIOM_PAD |
                                        {8'h0, ~req_buttons[7:0]}};
                     end
                     dgpr_pkg::REG_MISC:
                        s1_rdata_in = {16'h0, dgpr_pkg::MISC_VALUE};
                     dgpr_pkg::REG_WIDTH:
                        s1_rdata_in = {16'h0, dgpr_pkg::WIDTH_VALUE};
                     dgpr_pkg::REG_HEIGHT:
                        s1_rdata_in = {16'h0, dgpr_pkg::HEIGHT_VALUE};
                     dgpr_pkg::REG_LAYER_CTL:
                        s1_rdata_in = {16'h0, layer_ctl_ff};
                     dgpr_pkg::REG_FB_LO_A, dgpr_pkg::REG_FB_LO_B:
                        s1_rdata_in = {16'h0, frame_addr_ff[15:0]};
                     dgpr_pkg::REG_FB_HI_A, dgpr_pkg::REG_FB_HI_B:
                        s1_rdata_in = {16'h0, frame_addr_ff[31:16]};
                     dgpr_pkg::REG_PAL_ADDR:
                        s1_rdata_in = 32'(pal_idx_ff);
                     default:
                        rd16_hit = 1'b0;
                  endcase
               end
               // An unhandled address read twice in a row alternates its value.
               if (!rd16_hit) begin
                  if (req_address == last_unk_ff) begin
                     s1_rdata_in = {16'h0, toggle_ff};
                     toggle_in   = ~toggle_ff;
                  end
                  last_unk_in = req_address;
               end
            end
            dgpr_pkg::REQ_WRITE16: begin
               if (req_address[31:20] == dgpr_pkg::IO_PAGE12) begin
                  case (req_address[15:0])
                     dgpr_pkg::REG_LAYER_CTL:
                        layer_ctl_in = wd16 | dgpr_pkg::LAYER_OR_MASK;
                     dgpr_pkg::REG_FB_LO_B:
                        frame_addr_in = {frame_addr_ff[31:16], wd16};
                     dgpr_pkg::REG_FB_HI_B: begin
                        frame_addr_in = frame_hi_new;
                        s1_refresh_in = (frame_hi_new != prev_frame_ff);
                        prev_frame_in = frame_hi_new;
                     end
                     dgpr_pkg::REG_PAL_ADDR:
                        pal_idx_in = dgpr_pkg::PAL_IDX_W'(wd16 % dgpr_pkg::PALETTE_WORDS);
                     dgpr_pkg::REG_PAL_DATA: begin
                        pal_wr_en    = 1'b1;
                        pal_dirty_in = 1'b1;
                        pal_idx_in   =
                           (pal_idx_ff == dgpr_pkg::PAL_IDX_W'(dgpr_pkg::PALETTE_WORDS - 1))
                           ? '0 : pal_idx_ff + 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            dgpr_pkg::REQ_READ32: begin
               // The run register always reads as idle.
               if (blit_hit && (blit_off != dgpr_pkg::BLIT_RUN_OFF)) begin
                  blit_rd_en    = 1'b1;
                  s1_use_mem_in = 1'b1;
               end
            end
            dgpr_pkg::REQ_WRITE32: begin
               if (blit_hit) begin
                  blit_wr_en              = 1'b1;
                  blit_valid_in[blit_idx] = 1'b1;
                  s1_start_in = (blit_off == dgpr_pkg::BLIT_RUN_OFF) && req_write_data[0];
               end
            end
            dgpr_pkg::REQ_FLIP: begin
               s1_bpp_in  = (mode == 2'd0) ? 5'd4 : {mode, 3'b000};
               s1_base_in = frame_addr_ff;
               if ((mode[1] == 1'b0) && pal_dirty_ff) begin
                  s1_palchg_in = 1'b1;
                  pal_dirty_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pal_wr_en) begin
         pal_mem[pal_idx_ff] <= wd16;
      end
   end

   always_ff @(posedge clock) begin
      if (blit_wr_en) begin
         blit_mem[blit_idx] <= req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (blit_rd_en) begin
         blit_rdata_ff  <= blit_mem[blit_idx];
         blit_rvalid_ff <= blit_valid_ff[blit_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ctl_ff  <= dgpr_pkg::LAYER_RESET;
         frame_addr_ff <= dgpr_pkg::FRAME_RESET;
         prev_frame_ff <= '0;
         pal_idx_ff    <= '0;
         pal_dirty_ff  <= 1'b0;
         btn_latch_ff  <= '0;
         toggle_ff     <= '0;
         last_unk_ff   <= '0;
         blit_valid_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         layer_ctl_ff  <= layer_ctl_in;
         frame_addr_ff <= frame_addr_in;
         prev_frame_ff <= prev_frame_in;
         pal_idx_ff    <= pal_idx_in;
         pal_dirty_ff  <= pal_dirty_in;
         btn_latch_ff  <= btn_latch_in;
         toggle_ff     <= toggle_in;
         last_unk_ff   <= last_unk_in;
         blit_valid_ff <= blit_valid_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rdata_ff   <= s1_rdata_in;
         s1_use_mem_ff <= s1_use_mem_in;
         s1_start_ff   <= s1_start_in;
         s1_refresh_ff <= s1_refresh_in;
         s1_palchg_ff  <= s1_palchg_in;
         s1_bpp_ff     <= s1_bpp_in;
         s1_base_ff    <= s1_base_in;
      end
      if (s1_move) begin
         // A blitter register never written reads as zero.
         out_rdata_ff   <= s1_use_mem_ff ? (blit_rvalid_ff ? blit_rdata_ff : '0)
                                         : s1_rdata_ff;
         out_start_ff   <= s1_start_ff;
         out_refresh_ff <= s1_refresh_ff;
         out_palchg_ff  <= s1_palchg_ff;
         out_bpp_ff     <= s1_bpp_ff;
         out_base_ff    <= s1_base_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = out_rdata_ff;
   assign rsp_blit_start      = out_start_ff;
   assign rsp_refresh_request = out_refresh_ff;
   assign rsp_palette_changed = out_palchg_ff;
   assign rsp_display_bpp     = out_bpp_ff;
   assign rsp_frame_base      = out_base_ff;

   `DGPR_ASSERT_NEXT(a_stage_drains, clock, reset, s1_valid_ff && (!out_valid_ff || rsp_ready), rsp_valid)
   `DGPR_ASSERT_SAME(a_palchg_depth, clock, reset, rsp_valid && rsp_palette_changed, (rsp_display_bpp == 5'd4) || (rsp_display_bpp == 5'd8))
   `DGPR_ASSERT_SAME(a_start_alone, clock, reset, rsp_valid && rsp_blit_start, !rsp_refresh_request && !rsp_palette_changed && (rsp_display_bpp == 5'd0))
   `DGPR_ASSERT_NEXT(a_blit_marked, clock, reset, blit_wr_en, blit_valid_ff[$past(blit_idx)])

endmodule

@@ tb/display_gpio_palette_registers_tb.sv @@
// ----------------------------------------------------------------------------
// Display/GPIO register block testbench
// Drives 16-bit and 32-bit bus beats, flip events and reserved request codes into the register block
// and checks every response beat against an in-order prediction of the
// register file, with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module display_gpio_palette_registers_tb;

   localparam logic [2:0]  REQ_RESERVED_TOP = 3'd7;
   localparam logic [31:0] TCOUNT_ADDR      = {dgpr_pkg::IO_PAGE16, 16'h0a00};
   localparam int          HOLD_OFF_CYCLES  = 80;
   localparam int          REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [31:0] read_data;
      logic        blit_start;
      logic        refresh_request;
      logic        palette_changed;
      logic [4:0]  display_bpp;
      logic [31:0] frame_base;
   } bus_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = dgpr_pkg::REQ_READ16;
   logic [31:0] req_address = 32'h0;
   logic [31:0] req_write_data = 32'h0;
   logic [18:0] req_buttons = 19'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_blit_start;
   logic        rsp_refresh_request;
   logic        rsp_palette_changed;
   logic [4:0]  rsp_display_bpp;
   logic [31:0] rsp_frame_base;

   // Shadow copy of the register file.
   logic [15:0] layer_ctrl;
   logic [31:0] frame_addr;
   logic [31:0] prev_frame_addr;
   int unsigned pal_index;
   logic        pal_dirty;
   logic [31:0] blit_bank [dgpr_pkg::BLIT_REGS];
   logic [18:0] btn_latch;
   logic [15:0] toggle_word;
   logic [31:0] last_miss_addr;

   bus_response_type expected_responses [$];

   bit idle_enable = 1'b1;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;

   int mismatch_count = 0;
   int beats_sent = 0;
   int responses_checked = 0;
   int input_stall_cycles = 0;
   int refresh_seen = 0;
   int blit_start_seen = 0;
   int palette_change_seen = 0;

   display_gpio_palette_registers u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_address         (req_address),
      .req_write_data      (req_write_data),
      .req_buttons         (req_buttons),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_blit_start      (rsp_blit_start),
      .rsp_refresh_request (rsp_refresh_request),
      .rsp_palette_changed (rsp_palette_changed),
      .rsp_display_bpp     (rsp_display_bpp),
      .rsp_frame_base      (rsp_frame_base)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Timed out with %0d responses outstanding", expected_responses.size());
      $display("Mismatches found");
      $finish;
   end

   task automatic reset_shadow_registers();
      layer_ctrl      = dgpr_pkg::LAYER_RESET;
      frame_addr      = dgpr_pkg::FRAME_RESET;
      prev_frame_addr = 32'h0;
      pal_index       = 0;
      pal_dirty       = 1'b0;
      btn_latch       = 19'h0;
      toggle_word     = 16'h0;
      last_miss_addr  = 32'h0;
      for (int i = 0; i < dgpr_pkg::BLIT_REGS; i++) blit_bank[i] = 32'h0;
   endtask

   // Works out the response to one accepted beat and updates the shadow state.
   task automatic predict_response(input logic [2:0] kind, input logic [31:0] addr,
                                   input logic [31:0] data, input logic [18:0] btn,
                                   output bus_response_type r);
      logic [15:0] rd16;
      logic [11:0] off;
      bit          decoded;
      r = '0;
      rd16 = 16'h0;
      off = addr[11:0];
      case (kind)
         dgpr_pkg::REQ_READ16: begin
            decoded = 1'b0;
            if (addr[31:16] == dgpr_pkg::IO_PAGE16) begin
               decoded = 1'b1;
               case (addr[15:0])
                  dgpr_pkg::REG_ID_A, dgpr_pkg::REG_ID_B: rd16 = dgpr_pkg::ID_VALUE;
                  dgpr_pkg::REG_GPIOC: rd16 = {~btn_latch[15:8], 8'hff};
                  dgpr_pkg::REG_GPIOD:
                     rd16 = dgpr_pkg::GPIOD_PAD | {4'h0, ~btn_latch[18], 3'b000,
                                                   ~btn_latch[16], ~btn_latch[17], 6'h00};
                  dgpr_pkg::REG_GPIOM: begin
                     btn_latch = btn;
                     rd16 = dgpr_pkg::GPIOM_PAD | {8'h00, ~btn[7:0]};
                  end
                  dgpr_pkg::REG_MISC: rd16 = dgpr_pkg::MISC_VALUE;
                  dgpr_pkg::REG_WIDTH: rd16 = dgpr_pkg::WIDTH_VALUE;
                  dgpr_pkg::REG_HEIGHT: rd16 = dgpr_pkg::HEIGHT_VALUE;
                  dgpr_pkg::REG_LAYER_CTL: rd16 = layer_ctrl;
                  dgpr_pkg::REG_FB_LO_A, dgpr_pkg::REG_FB_LO_B: rd16 = frame_addr[15:0];
                  dgpr_pkg::REG_FB_HI_A, dgpr_pkg::REG_FB_HI_B: rd16 = frame_addr[31:16];
                  dgpr_pkg::REG_PAL_ADDR: rd16 = pal_index[15:0];
                  default: decoded = 1'b0;
               endcase
            end
            // Reading the same unmapped address again alternates between the
            // toggle word and its inverse.
            if (!decoded) begin
               rd16 = 16'h0;
               if (addr == last_miss_addr) begin
                  rd16 = toggle_word;
                  toggle_word = ~toggle_word;
               end
               last_miss_addr = addr;
            end
            r.read_data = {16'h0000, rd16};
         end
         dgpr_pkg::REQ_WRITE16: begin
            if (addr[31:20] == dgpr_pkg::IO_PAGE12) begin
               case (addr[15:0])
                  dgpr_pkg::REG_LAYER_CTL: layer_ctrl = data[15:0] | dgpr_pkg::LAYER_OR_MASK;
                  dgpr_pkg::REG_FB_LO_B: frame_addr[15:0] = data[15:0];
                  dgpr_pkg::REG_FB_HI_B: begin
                     frame_addr[31:16] = data[15:0];
                     r.refresh_request = (frame_addr != prev_frame_addr);
                     prev_frame_addr = frame_addr;
                  end
                  dgpr_pkg::REG_PAL_ADDR: pal_index = data[15:0] % dgpr_pkg::PALETTE_WORDS;
                  dgpr_pkg::REG_PAL_DATA: begin
                     pal_index = (pal_index + 1) % dgpr_pkg::PALETTE_WORDS;
                     pal_dirty = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         dgpr_pkg::REQ_READ32: begin
            if (addr[31:20] == dgpr_pkg::BLIT_PAGE12 && off < dgpr_pkg::BLIT_BYTES)
               r.read_data = (off == dgpr_pkg::BLIT_RUN_OFF) ? 32'h0 :
                             blit_bank[off[dgpr_pkg::BLIT_IDX_W+1:2]];
         end
         dgpr_pkg::REQ_WRITE32: begin
            if (addr[31:20] == dgpr_pkg::BLIT_PAGE12 && off < dgpr_pkg::BLIT_BYTES) begin
               blit_bank[off[dgpr_pkg::BLIT_IDX_W+1:2]] = data;
               r.blit_start = (off == dgpr_pkg::BLIT_RUN_OFF) && data[0];
            end
         end
         dgpr_pkg::REQ_FLIP: begin
            r.display_bpp = (layer_ctrl[10:9] == 2'b00) ? 5'd4 : {layer_ctrl[10:9], 3'b000};
            r.frame_base = frame_addr;
            if (r.display_bpp <= 5'd8 && pal_dirty) begin
               r.palette_changed = 1'b1;
               pal_dirty = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_access(input logic [2:0] kind, input logic [31:0] addr,
                              input logic [31:0] data, input logic [18:0] btn);
      bus_response_type want;
      while (idle_enable && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_address    <= addr;
      req_write_data <= data;
      req_buttons    <= btn;
      @(posedge clock);
      while (!req_ready) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      predict_response(kind, addr, data, btn, want);
      expected_responses.push_back(want);
      beats_sent++;
   endtask

   // Always waits on the clock before returning, so valid is never lowered and raised
   // again within one time step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   function automatic logic [15:0] pick_io_offset();
      case ($urandom_range(0, 15))
         0:  return dgpr_pkg::REG_ID_A;
         1:  return dgpr_pkg::REG_ID_B;
         2:  return dgpr_pkg::REG_GPIOC;
         3:  return dgpr_pkg::REG_GPIOD;
         4:  return dgpr_pkg::REG_GPIOM;
         5:  return dgpr_pkg::REG_MISC;
         6:  return dgpr_pkg::REG_WIDTH;
         7:  return dgpr_pkg::REG_HEIGHT;
         8:  return dgpr_pkg::REG_LAYER_CTL;
         9:  return dgpr_pkg::REG_FB_LO_A;
         10: return dgpr_pkg::REG_FB_HI_A;
         11: return dgpr_pkg::REG_FB_LO_B;
         12: return dgpr_pkg::REG_FB_HI_B;
         13: return dgpr_pkg::REG_PAL_ADDR;
         14: return dgpr_pkg::REG_PAL_DATA;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_access();
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [31:0] data;
      logic [11:0] off;
      int          roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         kind = 3'($urandom_range(int'(dgpr_pkg::REQ_FLIP) + 1, int'(REQ_RESERVED_TOP)));
      else if (roll < 33) kind = dgpr_pkg::REQ_READ16;
      else if (roll < 63) kind = dgpr_pkg::REQ_WRITE16;
      else if (roll < 75) kind = dgpr_pkg::REQ_READ32;
      else if (roll < 87) kind = dgpr_pkg::REQ_WRITE32;
      else                kind = dgpr_pkg::REQ_FLIP;
      data = $urandom;
      addr = $urandom;
      roll = $urandom_range(0, 99);
      if (kind == dgpr_pkg::REQ_READ16 || kind == dgpr_pkg::REQ_WRITE16) begin
         // Mostly mapped registers; aliases in the wider write window and
         // repeats of the last unmapped address reach the toggle behaviour.
         if (roll < 70)      addr = {dgpr_pkg::IO_PAGE16, pick_io_offset()};
         else if (roll < 80) addr = {dgpr_pkg::IO_PAGE12, 4'($urandom), pick_io_offset()};
         else if (roll < 90) addr = last_miss_addr;
         if (kind == dgpr_pkg::REQ_WRITE16 && addr[15:0] == dgpr_pkg::REG_FB_HI_B &&
             $urandom_range(0, 99) < 35)
            data[15:0] = frame_addr[31:16];
      end else if (kind == dgpr_pkg::REQ_READ32 || kind == dgpr_pkg::REQ_WRITE32) begin
         if (roll < 85) begin
            case ($urandom_range(0, 9))
               0, 1:    off = dgpr_pkg::BLIT_RUN_OFF;
               2:       off = 12'($urandom);
               default: off = 12'(4 * $urandom_range(0, dgpr_pkg::BLIT_REGS));
            endcase
            addr = {dgpr_pkg::BLIT_PAGE12, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
                    off};
         end else if (roll < 92) begin
            addr = TCOUNT_ADDR;
         end
      end
      send_access(kind, addr, data, 19'($urandom));
   endtask

   task automatic test_gpio_reads();
      send_access(dgpr_pkg::REQ_READ16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_GPIOM},
                  32'h0, 19'h7ffff);
      send_access(dgpr_pkg::REQ_READ16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_GPIOD},
                  32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_READ16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_GPIOM},
                  32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_READ16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_GPIOC},
                  32'h0, 19'h0);
   endtask

   task automatic test_layer_and_frame();
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_LAYER_CTL},
                  32'hffff_ffff, 19'h0);
      send_access(dgpr_pkg::REQ_FLIP, 32'h0, 32'h0, 19'h0);
      // The first pair of frame registers ignores writes.
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_FB_HI_A},
                  32'h0000_1234, 19'h0);
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_FB_HI_B},
                  32'h0000_ffff, 19'h0);
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_FB_HI_B},
                  32'h0000_ffff, 19'h0);
   endtask

   task automatic test_palette_wrap();
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_PAL_ADDR},
                  32'h0000_ffff, 19'h0);
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_PAL_DATA},
                  32'h0000_5a5a, 19'h0);
      send_access(dgpr_pkg::REQ_READ16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_PAL_ADDR},
                  32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_WRITE16, {dgpr_pkg::IO_PAGE16, dgpr_pkg::REG_LAYER_CTL},
                  32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_FLIP, 32'h0, 32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_FLIP, 32'hffff_ffff, 32'hffff_ffff, 19'h7ffff);
   endtask

   task automatic test_blitter_bank();
      send_access(dgpr_pkg::REQ_WRITE32,
                  {dgpr_pkg::BLIT_PAGE12, 8'h00, dgpr_pkg::BLIT_RUN_OFF}, 32'h0000_0001, 19'h0);
      send_access(dgpr_pkg::REQ_READ32,
                  {dgpr_pkg::BLIT_PAGE12, 8'h00, dgpr_pkg::BLIT_RUN_OFF}, 32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_WRITE32,
                  {dgpr_pkg::BLIT_PAGE12, 8'h00, 12'(dgpr_pkg::BLIT_BYTES - 4)},
                  32'hffff_ffff, 19'h0);
      send_access(dgpr_pkg::REQ_READ32,
                  {dgpr_pkg::BLIT_PAGE12, 8'h00, 12'(dgpr_pkg::BLIT_BYTES - 4)}, 32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_READ32,
                  {dgpr_pkg::BLIT_PAGE12, 8'h00, 12'(dgpr_pkg::BLIT_BYTES)}, 32'h0, 19'h0);
   endtask

   task automatic test_unmapped_reads();
      // Address zero matches the reset value of the last unmapped address.
      send_access(dgpr_pkg::REQ_READ16, 32'h0, 32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_READ16, 32'h0, 32'h0, 19'h0);
      send_access(dgpr_pkg::REQ_READ16, 32'hffff_ffff, 32'h0, 19'h0);
      send_access(REQ_RESERVED_TOP, 32'hffff_ffff, 32'hffff_ffff, 19'h7ffff);
   endtask

   task automatic test_random_traffic(input int beats);
      repeat (beats) send_random_access();
   endtask

   task automatic test_unbroken_stretch(input int beats);
      idle_enable = 1'b0;
      repeat (beats) send_random_access();
      idle_enable = 1'b1;
   endtask

   // The sink holds off while the source keeps offering, so the block fills.
   task automatic test_receiver_hold_off(input int beats);
      idle_enable = 1'b0;
      hold_off_requests++;
      repeat (beats) send_random_access();
      idle_enable = 1'b1;
   endtask

   task automatic test_sender_pause(input int bursts, input int beats);
      repeat (bursts) begin
         repeat (beats) send_random_access();
         wait_for_drain();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected 0x%08h, got 0x%08h", $time, name, want, got);
      end
   endtask

   task automatic check_response();
      bus_response_type want;
      if (expected_responses.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: response beat with none expected, read_data 0x%08h",
                     $time, rsp_read_data);
         return;
      end
      want = expected_responses.pop_front();
      compare_field("read_data", want.read_data, rsp_read_data);
      compare_field("blit_start", 32'(want.blit_start), 32'(rsp_blit_start));
      compare_field("refresh_request", 32'(want.refresh_request), 32'(rsp_refresh_request));
      compare_field("palette_changed", 32'(want.palette_changed), 32'(rsp_palette_changed));
      compare_field("display_bpp", 32'(want.display_bpp), 32'(rsp_display_bpp));
      compare_field("frame_base", want.frame_base, rsp_frame_base);
      responses_checked++;
      if (want.refresh_request) refresh_seen++;
      if (want.blit_start) blit_start_seen++;
      if (want.palette_changed) palette_change_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_response();
   end

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_served + 1;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enable && $urandom_range(0, 99) < 23);
      end
   end

   initial begin
      reset_shadow_registers();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_gpio_reads();
      test_layer_and_frame();
      test_palette_wrap();
      test_blitter_bank();
      test_unmapped_reads();
      test_random_traffic(700);
      test_unbroken_stretch(300);
      test_receiver_hold_off(120);
      test_sender_pause(4, 50);
      test_receiver_hold_off(60);
      test_random_traffic(420);

      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d request beats and %0d checked responses; input stalled %0d cycles.",
               beats_sent, responses_checked, input_stall_cycles);
      $display("Saw %0d refresh requests, %0d blitter starts and %0d palette changes.",
               refresh_seen, blit_start_seen, palette_change_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
